// ----- hw/rtl/bsw_pkg.sv -----
`default_nettype none

package bsw_pkg;

    localparam int DIM_W         = 13;
    localparam int MAX_DIMENSION = 4096;
    localparam int COUNT_W       = 12;
    localparam int HDR_LEN       = 54;
    localparam int HDR_CNT_W     = 6;
    localparam int ROW_BYTES_W   = 15;
    localparam int IMG_W         = 28;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] MAGIC_WORD     = 16'h4D42;
    localparam logic [31:0] PELS_PER_METRE = 32'd2952;
    localparam logic [31:0] INFO_HDR_LEN   = 32'd40;
    localparam logic [31:0] BPP_THREE      = 32'd24;
    localparam logic [31:0] BPP_FOUR       = 32'd32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_CHANNEL = 2'd2;

    // Frame geometry as seen by the front and back parts, already clamped.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             four_channel;
        logic [1:0]       row_pad;
        logic [IMG_W-1:0] image_size;
    } frame_cfg_t;

    // One classified pixel request waiting for the byte sequencer.
    typedef struct packed {
        logic       header;
        logic [1:0] pad;
        logic       frame_end;
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } pix_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmp_stream_writer.sv -----
// Turns a stream of pixels into an uncompressed BMP file byte stream, one byte per cycle
// on the output unless m_tready is low or the queue is empty. Each input request carries
// one pixel (first byte in s_tdata[7:0]); the first pixel of a frame is preceded by the
// 54-byte header, 24-bit pixels come out in reverse byte order, 32-bit pixels unchanged,
// and each row is padded with zero bytes to a 4-byte boundary. m_tlast closes the bytes
// of each pixel and m_tuser marks the final byte of the file. A pixel takes 3 bytes in
// 24-bit mode or 4 in 32-bit mode, plus 0 to 3 row pad bytes and the header on the first
// pixel of a frame. A four-entry request queue lets the input side accept a pixel every
// cycle until it fills. The user must write configuration (width, height, channel count)
// only while no pixel is in flight; the block itself does not enforce this.
`default_nettype none

module bmp_stream_writer
    import bsw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // first_byte [7:0], second_byte [15:8], third_byte [23:16], fourth_byte [31:24]
    input  wire logic [31:0]          s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_byte [7:0]
    output logic [7:0]                m_tdata,
    // last_of_run
    output logic                      m_tlast,
    // end_of_file [0]
    output logic                      m_tuser
);

    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    logic                   four_channel_reg;
    logic [IMG_W-1:0]       img_reg;
    logic [DIM_W-1:0]       width_c;
    logic [DIM_W-1:0]       height_c;
    logic [1:0]             row_pad;
    logic [ROW_BYTES_W-1:0] row_bytes;
    frame_cfg_t             cfg;
    pix_req_t               q_din;
    pix_req_t               q_head;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg        <= 13'd1;
            height_reg       <= 13'd1;
            four_channel_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg        <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg       <= cfg_data;
                CFG_FOUR_CHANNEL: four_channel_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            width_c = 13'd1;
        end else if (width_reg > DIM_W'(MAX_DIMENSION)) begin
            width_c = DIM_W'(MAX_DIMENSION);
        end else begin
            width_c = width_reg;
        end
        if (height_reg == '0) begin
            height_c = 13'd1;
        end else if (height_reg > DIM_W'(MAX_DIMENSION)) begin
            height_c = DIM_W'(MAX_DIMENSION);
        end else begin
            height_c = height_reg;
        end
        // Three bytes per pixel leave a row short of alignment by the width modulo four.
        row_pad = four_channel_reg ? 2'd0 : width_c[1:0];
        if (four_channel_reg) begin
            row_bytes = {width_c, 2'b00};
        end else begin
            row_bytes = {2'b00, width_c} + {1'b0, width_c, 1'b0} + {13'd0, row_pad};
        end
    end

    always_ff @(posedge aclk) begin
        img_reg <= IMG_W'(row_bytes) * IMG_W'(height_c);
    end

    assign cfg.width        = width_c;
    assign cfg.height       = height_c;
    assign cfg.four_channel = four_channel_reg;
    assign cfg.row_pad      = row_pad;
    assign cfg.image_size   = img_reg;

    bsw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_din    (q_din)
    );

    bsw_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    bsw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/bsw_front.sv -----
`default_nettype none

module bsw_front
    import bsw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire frame_cfg_t cfg,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic       q_full,
    output logic            q_push,
    output pix_req_t        q_din
);

    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic               hdr_done_reg, hdr_done_next;
    logic               row_end;
    logic               frame_end;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        row_end   = ({1'b0, col_reg} + 13'd1) >= cfg.width;
        frame_end = row_end && (({1'b0, row_reg} + 13'd1) >= cfg.height);

        q_din.header    = !hdr_done_reg;
        q_din.pad       = row_end ? cfg.row_pad : 2'd0;
        q_din.frame_end = frame_end;
        q_din.b0        = s_tdata[7:0];
        q_din.b1        = s_tdata[15:8];
        q_din.b2        = s_tdata[23:16];
        q_din.b3        = s_tdata[31:24];

        col_next      = col_reg;
        row_next      = row_reg;
        hdr_done_next = hdr_done_reg;
        if (q_push) begin
            hdr_done_next = 1'b1;
            if (row_end) begin
                col_next = '0;
                if (frame_end) begin
                    row_next      = '0;
                    hdr_done_next = 1'b0;
                end else begin
                    row_next = row_reg + 12'd1;
                end
            end else begin
                col_next = col_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            hdr_done_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            hdr_done_reg <= hdr_done_next;
        end
    end

    // The pixel that closes a frame leaves the counters ready for a new header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_din.frame_end) |=> (!hdr_done_reg && col_reg == '0 && row_reg == '0))
        else $error("frame end did not rewind the front counters");

endmodule

`default_nettype wire

// ----- hw/rtl/bsw_fifo.sv -----
`default_nettype none

module bsw_fifo
    import bsw_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire pix_req_t din,
    input  wire logic     pop,
    output pix_req_t      dout,
    output logic          full,
    output logic          empty
);

    pix_req_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue popped while empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !empty)
        else $error("queue lost a pushed request");

endmodule

`default_nettype wire

// ----- hw/rtl/bsw_back.sv -----
`default_nettype none

module bsw_back
    import bsw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire frame_cfg_t cfg,
    input  wire pix_req_t   head,
    input  wire logic       q_empty,
    output logic            q_pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    typedef enum logic [1:0] {
        ST_START,
        ST_HDR,
        ST_PIX,
        ST_PAD
    } back_state_t;

    back_state_t          st_reg, st_next, st_eff;
    logic [HDR_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_tvalid_reg;
    logic [7:0]           m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;
    logic                 load;
    logic [7:0]           cur_byte;
    logic                 cur_last;
    logic                 pix_done;
    logic [1:0]           pix_last_idx;

    function automatic logic [7:0] header_byte(input logic [HDR_CNT_W-1:0] idx,
                                               input frame_cfg_t c);
        logic [31:0] img;
        logic [31:0] total;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] bpp;
        logic [31:0] off;
        img   = {{(32-IMG_W){1'b0}}, c.image_size};
        total = img + 32'(HDR_LEN);
        w     = {{(32-DIM_W){1'b0}}, c.width};
        h     = {{(32-DIM_W){1'b0}}, c.height};
        bpp   = c.four_channel ? BPP_FOUR : BPP_THREE;
        off   = 32'(HDR_LEN);
        case (idx)
            6'd0:    header_byte = MAGIC_WORD[7:0];
            6'd1:    header_byte = MAGIC_WORD[15:8];
            6'd2:    header_byte = total[7:0];
            6'd3:    header_byte = total[15:8];
            6'd4:    header_byte = total[23:16];
            6'd5:    header_byte = total[31:24];
            6'd10:   header_byte = off[7:0];
            6'd14:   header_byte = INFO_HDR_LEN[7:0];
            6'd18:   header_byte = w[7:0];
            6'd19:   header_byte = w[15:8];
            6'd22:   header_byte = h[7:0];
            6'd23:   header_byte = h[15:8];
            6'd26:   header_byte = 8'd1;
            6'd28:   header_byte = bpp[7:0];
            6'd34:   header_byte = img[7:0];
            6'd35:   header_byte = img[15:8];
            6'd36:   header_byte = img[23:16];
            6'd37:   header_byte = img[31:24];
            6'd38:   header_byte = PELS_PER_METRE[7:0];
            6'd39:   header_byte = PELS_PER_METRE[15:8];
            6'd42:   header_byte = PELS_PER_METRE[7:0];
            6'd43:   header_byte = PELS_PER_METRE[15:8];
            default: header_byte = 8'd0;
        endcase
    endfunction

    assign load     = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        // A fresh request starts straight in its first phase, with no dead cycle.
        if (st_reg == ST_START) begin
            st_eff = head.header ? ST_HDR : ST_PIX;
        end else begin
            st_eff = st_reg;
        end
        pix_last_idx = cfg.four_channel ? 2'd3 : 2'd2;
        pix_done     = cnt_reg[1:0] == pix_last_idx;
        cur_byte     = 8'd0;
        cur_last     = 1'b0;
        st_next      = st_reg;
        cnt_next     = cnt_reg + 6'd1;
        case (st_eff)
            ST_HDR: begin
                cur_byte = header_byte(cnt_reg, cfg);
                if (cnt_reg == 6'(HDR_LEN - 1)) begin
                    st_next  = ST_PIX;
                    cnt_next = '0;
                end else begin
                    st_next = ST_HDR;
                end
            end
            ST_PIX: begin
                if (cfg.four_channel) begin
                    case (cnt_reg[1:0])
                        2'd0:    cur_byte = head.b0;
                        2'd1:    cur_byte = head.b1;
                        2'd2:    cur_byte = head.b2;
                        default: cur_byte = head.b3;
                    endcase
                end else begin
                    case (cnt_reg[1:0])
                        2'd0:    cur_byte = head.b2;
                        2'd1:    cur_byte = head.b1;
                        default: cur_byte = head.b0;
                    endcase
                end
                cur_last = pix_done && (head.pad == 2'd0);
                if (pix_done) begin
                    st_next  = (head.pad == 2'd0) ? ST_START : ST_PAD;
                    cnt_next = '0;
                end else begin
                    st_next = ST_PIX;
                end
            end
            ST_PAD: begin
                cur_byte = 8'd0;
                cur_last = cnt_reg[1:0] == (head.pad - 2'd1);
                if (cur_last) begin
                    st_next  = ST_START;
                    cnt_next = '0;
                end else begin
                    st_next = ST_PAD;
                end
            end
            default: begin
                cur_byte = 8'd0;
                cur_last = 1'b0;
            end
        endcase
    end

    assign q_pop = load && !q_empty && cur_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_START;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= !q_empty;
            m_tdata_reg  <= cur_byte;
            m_tlast_reg  <= cur_last;
            m_tuser_reg  <= cur_last && head.frame_end;
            if (!q_empty) begin
                st_reg  <= st_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> m_tlast_reg)
        else $error("end of file flagged on a byte that does not close its request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_PAD) |-> (!q_empty && head.pad != 2'd0))
        else $error("padding phase without a padded request at the queue head");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_HDR) |-> (cnt_reg < 6'(HDR_LEN)))
        else $error("header byte counter ran past the header");

endmodule

`default_nettype wire

// ----- tb/bmp_stream_writer_checker.sv -----
module bmp_stream_writer_checker
    import bsw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [31:0]          s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [7:0]           m_tdata,
    input  wire logic                 m_tlast,
    input  wire logic                 m_tuser,
    output int                        mismatch_count,
    output int                        bytes_outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       pixel_end;
        logic       file_end;
    } file_byte_t;

    file_byte_t file_bytes[$];

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               four_reg;
    logic [COUNT_W-1:0] column_pos;
    logic [COUNT_W-1:0] row_pos;
    logic               header_sent;
    int                 errors = 0;

    function automatic int unsigned bounded_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIMENSION) return MAX_DIMENSION;
        return v;
    endfunction

    // Appends the header (if a frame starts here), the pixel bytes and any row padding.
    function automatic void predict_pixel(input logic [31:0] pixel);
        int unsigned          w;
        int unsigned          h;
        int unsigned          bpp;
        int unsigned          image_size;
        int unsigned          pad;
        logic                 row_end;
        logic                 frame_end;
        logic [HDR_LEN*8-1:0] header;
        logic [7:0]           run[$];
        file_byte_t           entry;

        w         = bounded_dim(width_reg);
        h         = bounded_dim(height_reg);
        bpp       = four_reg ? BPP_FOUR : BPP_THREE;
        row_end   = (column_pos + 1 >= w);
        frame_end = row_end && (row_pos + 1 >= h);
        pad       = row_end ? (4 - (w * (bpp / 8)) % 4) % 4 : 0;

        if (!header_sent) begin
            image_size           = ((w * bpp + 31) / 32) * 4 * h;
            header               = '0;
            header[0 +: 16]      = MAGIC_WORD;
            header[16 +: 32]     = image_size + HDR_LEN;
            header[80 +: 32]     = HDR_LEN;
            header[112 +: 32]    = INFO_HDR_LEN;
            header[144 +: 32]    = w;
            header[176 +: 32]    = h;
            header[208 +: 16]    = 16'd1;
            header[224 +: 16]    = bpp[15:0];
            header[272 +: 32]    = image_size;
            header[304 +: 32]    = PELS_PER_METRE;
            header[336 +: 32]    = PELS_PER_METRE;
            for (int i = 0; i < HDR_LEN; i++) run.push_back(header[8*i +: 8]);
            header_sent = 1'b1;
        end

        if (four_reg) begin
            for (int i = 0; i < 4; i++) run.push_back(pixel[8*i +: 8]);
        end else begin
            // Three-byte pixels leave in reverse order and the fourth byte is dropped.
            for (int i = 2; i >= 0; i--) run.push_back(pixel[8*i +: 8]);
        end
        for (int i = 0; i < pad; i++) run.push_back(8'h00);

        if (row_end) begin
            column_pos = '0;
            if (frame_end) begin
                row_pos     = '0;
                header_sent = 1'b0;
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            column_pos = column_pos + 1'b1;
        end

        for (int i = 0; i < run.size(); i++) begin
            entry.data      = run[i];
            entry.pixel_end = (i == run.size() - 1);
            entry.file_end  = (i == run.size() - 1) && frame_end;
            file_bytes.push_back(entry);
        end
    endfunction

    always @(posedge aclk) begin
        file_byte_t want;
        if (!aresetn) begin
            width_reg   = 1;
            height_reg  = 1;
            four_reg    = 1'b0;
            column_pos  = '0;
            row_pos     = '0;
            header_sent = 1'b0;
            file_bytes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg = cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg = cfg_data;
                    CFG_FOUR_CHANNEL: four_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_pixel(s_tdata);
            if (m_tvalid && m_tready) begin
                if (file_bytes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected byte %02h last %b eof %b", $time,
                                 m_tdata, m_tlast, m_tuser);
                end else begin
                    want = file_bytes.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.pixel_end ||
                        m_tuser !== want.file_end) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: expected byte %02h last %b eof %b, got %02h %b %b",
                                     $time, want.data, want.pixel_end, want.file_end,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
        mismatch_count    <= errors;
        bytes_outstanding <= file_bytes.size();
    end

endmodule

// ----- tb/bmp_stream_writer_test.sv -----
module bmp_stream_writer_test;
    import bsw_pkg::*;

    localparam int RANDOM_PIXELS = 440;
    localparam int QUIET_PIXELS  = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 3_000_000;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    logic idle_enable = 1'b1;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   mismatch_count;
    int   bytes_outstanding;

    bmp_stream_writer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    bmp_stream_writer_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .m_tuser           (m_tuser),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // While idle_enable is set, output stalls come in random bursts.
    always @(posedge aclk) begin
        if (!idle_enable) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[DIM_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned four);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_FOUR_CHANNEL, four);
    endtask

    // Returns at the edge where the request is taken; valid stays high for a follower.
    task automatic send_pixel(input logic [31:0] pixel);
        int gap;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bytes_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          sent;
        int unsigned pw;
        int unsigned ph;
        int unsigned frame_pixels;
        int unsigned pixels;

        sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Geometry left at its reset value: one-pixel frames with three-byte pixels.
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        drain();

        // Zero dimensions count as one.
        set_geometry(0, 0, 1);
        send_pixel(32'hA5C3_5A3C);
        drain();

        // Oversized width is clamped; the row and then the frame are closed early by
        // lowering the dimensions part way through.
        set_geometry(8191, 4096, 0);
        send_pixel(32'h0102_0304);
        send_pixel(32'h8040_2010);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 3);
        send_pixel(32'hFEDC_BA98);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 1);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        send_pixel(32'h3C00_FF5A);
        drain();

        set_geometry(4096, 1, 1);
        send_pixel(32'h7F7F_8080);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 2);
        send_pixel(32'h5555_AAAA);
        drain();

        set_geometry(5, 2, 0);
        repeat (10) send_pixel($urandom);
        drain();

        while (sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 19))
                0:       pw = $urandom_range(0, 8191);
                1, 2, 3: pw = $urandom_range(9, 24);
                default: pw = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 19))
                0:       ph = $urandom_range(0, 8191);
                1:       ph = 0;
                default: ph = $urandom_range(1, 4);
            endcase
            set_geometry(pw, ph, $urandom_range(0, 1));
            frame_pixels = (pw == 0 ? 1 : pw) * (ph == 0 ? 1 : ph);
            // Mostly whole frames; sometimes a frame is left open for the next setting.
            if (frame_pixels > 48 || $urandom_range(0, 5) == 0)
                pixels = $urandom_range(1, 48);
            else
                pixels = frame_pixels * $urandom_range(1, 3);
            if (sent >= RANDOM_PIXELS - QUIET_PIXELS)
                idle_enable <= 1'b0;
            else
                idle_enable <= ($urandom_range(0, 3) != 0);
            repeat (pixels) begin
                send_pixel($urandom);
                sent++;
            end
            drain();
        end

        if (mismatch_count == 0 && bytes_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
